// File: hw/rtl/cbm_pkg.sv
`timescale 1ns / 1ps

package cbm_pkg;

  // Address decode of a bus write.
  localparam logic [15:0] ADDR_MASK     = 16'hf030;
  localparam logic [15:0] ADDR_PRG0     = 16'h8000;
  localparam logic [15:0] ADDR_PRG1     = 16'h8010;
  localparam logic [15:0] ADDR_PRG2     = 16'h9000;
  localparam logic [15:0] ADDR_CHR0     = 16'ha000;
  localparam logic [15:0] ADDR_CHR1     = 16'ha010;
  localparam logic [15:0] ADDR_CHR2     = 16'hb000;
  localparam logic [15:0] ADDR_CHR3     = 16'hb010;
  localparam logic [15:0] ADDR_CHR4     = 16'hc000;
  localparam logic [15:0] ADDR_CHR5     = 16'hc010;
  localparam logic [15:0] ADDR_CHR6     = 16'hd000;
  localparam logic [15:0] ADDR_CHR7     = 16'hd010;
  localparam logic [15:0] ADDR_MIRROR   = 16'he000;
  localparam logic [15:0] ADDR_IRQ_LTCH = 16'he010;
  localparam logic [15:0] ADDR_IRQ_CTRL = 16'hf000;
  localparam logic [15:0] ADDR_IRQ_ACK  = 16'hf010;

  // Item kind.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_PRG    = 2'd1,
    EV_CHR    = 2'd2,
    EV_MIRROR = 2'd3
  } event_kind_e;

  localparam logic [8:0] PRG_COUNT_RESET = 9'd32;
  localparam logic [7:0] IRQ_FULL        = 8'hff;
  localparam int unsigned DATA_BITS      = 8;

endpackage

// File: hw/rtl/cartridge_bank_mapper_with_line_irq.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   func_i, address_i, data_i
// out       output     out_valid_o / out_stall_i event_kind_o, slot_o, bank_value_o,
//                                                irq_request_o
// cfg       input      cfg_we_i                  cfg_wdata_i (program bank count)
//
// A tick or a non-program write has its result registered at accept. A program bank
// write runs a bit-serial restoring remainder that shifts one data bit per cycle
// through eight steps, then loads the result once the output register is free.
// Reset clears the interrupt state and sets the bank count to 32.
// An item is accepted while a result waits, as long as the output register frees in
// that cycle; the remainder unit holds its result while the output stays stalled.
module cartridge_bank_mapper_with_line_irq
  import cbm_pkg::*;
#(
  parameter int unsigned CHR_BANK_BITS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [15:0] address_i,
  input  logic [7:0] data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_kind_o,
  output logic [2:0] slot_o,
  output logic [7:0] bank_value_o,
  output logic       irq_request_o
);

  localparam logic [7:0] ChrMask = 8'((9'd1 << CHR_BANK_BITS) - 9'd1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic       state_q;
  logic [3:0] step_q;
  logic [7:0] div_q;
  logic [8:0] rem_q;
  logic [2:0] pend_slot_q;
  logic [8:0] prg_count_q;

  logic [7:0] irq_reload_q;
  logic [7:0] irq_count_q;
  logic       irq_armed_q;
  logic       irq_rearm_q;

  logic       out_valid_q;
  logic [1:0] event_kind_q;
  logic [2:0] slot_q;
  logic [7:0] bank_value_q;
  logic       irq_request_q;

  logic        in_accept;
  logic        out_free;
  logic [15:0] masked;
  logic        is_prg;
  event_kind_e dec_kind;
  logic [2:0]  dec_slot;
  logic [7:0]  dec_value;
  logic        tick_irq;
  logic [9:0]  trial;
  logic        trial_ge;
  logic [8:0]  rem_d;
  logic        calc_done;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_CALC) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign masked     = address_i & ADDR_MASK;
  assign calc_done  = (state_q == ST_CALC) && (step_q == 4'(DATA_BITS)) && out_free;

  assign tick_irq = irq_armed_q && (irq_count_q == 8'd0);

  always_comb begin
    is_prg    = 1'b0;
    dec_kind  = EV_NONE;
    dec_slot  = 3'd0;
    dec_value = 8'd0;
    case (masked)
      ADDR_PRG0: begin is_prg = 1'b1; dec_slot = 3'd0; end
      ADDR_PRG1: begin is_prg = 1'b1; dec_slot = 3'd1; end
      ADDR_PRG2: begin is_prg = 1'b1; dec_slot = 3'd2; end
      ADDR_CHR0: begin dec_kind = EV_CHR; dec_slot = 3'd0; end
      ADDR_CHR1: begin dec_kind = EV_CHR; dec_slot = 3'd1; end
      ADDR_CHR2: begin dec_kind = EV_CHR; dec_slot = 3'd2; end
      ADDR_CHR3: begin dec_kind = EV_CHR; dec_slot = 3'd3; end
      ADDR_CHR4: begin dec_kind = EV_CHR; dec_slot = 3'd4; end
      ADDR_CHR5: begin dec_kind = EV_CHR; dec_slot = 3'd5; end
      ADDR_CHR6: begin dec_kind = EV_CHR; dec_slot = 3'd6; end
      ADDR_CHR7: begin dec_kind = EV_CHR; dec_slot = 3'd7; end
      ADDR_MIRROR: begin
        dec_kind  = EV_MIRROR;
        dec_value = data_i & 8'h03;
      end
      default: begin
        dec_kind = EV_NONE;
      end
    endcase
    if (dec_kind == EV_CHR) begin
      dec_value = data_i & ChrMask;
    end
  end

  // One restoring step. A zero count always subtracts nothing and a count above
  // the byte range never subtracts, so both pass the data byte unchanged.
  assign trial    = {rem_q, div_q[7]};
  assign trial_ge = trial >= {1'b0, prg_count_q};
  assign rem_d    = trial_ge ? 9'(trial - {1'b0, prg_count_q}) : trial[8:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= PRG_COUNT_RESET;
    end else if (cfg_we_i) begin
      prg_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_reload_q <= 8'd0;
      irq_count_q  <= 8'd0;
      irq_armed_q  <= 1'b0;
      irq_rearm_q  <= 1'b0;
    end else if (in_accept) begin
      if (func_i == FUNC_TICK) begin
        if (tick_irq) begin
          irq_armed_q <= 1'b0;
        end else if (irq_armed_q) begin
          irq_count_q <= irq_count_q - 8'd1;
        end
      end else begin
        case (masked)
          ADDR_IRQ_LTCH: begin
            irq_reload_q <= IRQ_FULL - data_i;
          end
          ADDR_IRQ_CTRL: begin
            irq_rearm_q <= data_i[0];
            irq_armed_q <= data_i[1];
            irq_count_q <= irq_reload_q;
          end
          ADDR_IRQ_ACK: begin
            irq_armed_q <= irq_rearm_q;
            irq_count_q <= irq_reload_q;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 4'd0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_accept && (func_i == FUNC_WRITE) && is_prg) begin
            state_q <= ST_CALC;
            step_q  <= 4'd0;
          end
        end
        ST_CALC: begin
          if (step_q != 4'(DATA_BITS)) begin
            step_q <= step_q + 4'd1;
          end else if (calc_done) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      div_q       <= data_i;
      rem_q       <= 9'd0;
      pend_slot_q <= dec_slot;
    end else if ((state_q == ST_CALC) && (step_q != 4'(DATA_BITS))) begin
      div_q <= {div_q[6:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_accept && !((func_i == FUNC_WRITE) && is_prg)) || calc_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (calc_done) begin
      event_kind_q  <= EV_PRG;
      slot_q        <= pend_slot_q;
      bank_value_q  <= rem_q[7:0];
      irq_request_q <= 1'b0;
    end else if (in_accept) begin
      if (func_i == FUNC_TICK) begin
        event_kind_q  <= EV_NONE;
        slot_q        <= 3'd0;
        bank_value_q  <= 8'd0;
        irq_request_q <= tick_irq;
      end else if (!is_prg) begin
        event_kind_q  <= dec_kind;
        slot_q        <= (dec_kind == EV_CHR) ? dec_slot : 3'd0;
        bank_value_q  <= dec_value;
        irq_request_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = event_kind_q;
  assign slot_o        = slot_q;
  assign bank_value_o  = bank_value_q;
  assign irq_request_o = irq_request_q;

`ifndef ASSERT_OFF
  a_step_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 4'(DATA_BITS))
    else $error("remainder step counter out of range");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) && (step_q != 4'd0) && (prg_count_q != 9'd0)
      |-> rem_q < prg_count_q)
    else $error("partial remainder not below bank count");

  a_irq_disarm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (func_i == FUNC_TICK) && tick_irq |=> !irq_armed_q)
    else $error("interrupt did not disarm the counter");

  a_irq_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && irq_request_q |-> event_kind_q == EV_NONE)
    else $error("interrupt reported with a mapping change");

  a_no_accept_calc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) && !calc_done |=> !$past(in_accept))
    else $error("item accepted during remainder");
`endif

endmodule

// File: verif/cartridge_bank_mapper_with_line_irq_tb.sv
`timescale 1ns / 1ps

module cartridge_bank_mapper_with_line_irq_tb;
  import cbm_pkg::*;

  localparam int unsigned CHR_BITS = 6;
  localparam logic [7:0] CHR_MASK = 8'((1 << CHR_BITS) - 1);
  localparam logic [7:0] MIRROR_MASK = 8'h03;
  localparam logic [15:0] SND_ADDR_LO = 16'h9010;
  localparam logic [15:0] SND_ADDR_HI = 16'h9030;
  localparam logic [15:0] ADDR_FREE_BITS = ~ADDR_MASK;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS = 420;

  typedef struct packed {
    event_kind_e kind;
    logic [2:0]  slot;
    logic [7:0]  bank;
    logic        irq;
  } mapping_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = FUNC_WRITE;
  logic [15:0] address_i = '0;
  logic [7:0]  data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  event_kind_o;
  logic [2:0]  slot_o;
  logic [7:0]  bank_value_o;
  logic        irq_request_o;

  // Shadow copy of the mapper state.
  logic [8:0] bank_count_m = PRG_COUNT_RESET;
  logic [7:0] line_reload = '0;
  logic [7:0] line_count = '0;
  logic       line_armed = 1'b0;
  logic       line_rearm = 1'b0;

  mapping_event_t expected_events[$];
  int unsigned    error_count = 0;
  int unsigned    items_sent = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct = 0;

  cartridge_bank_mapper_with_line_irq #(
    .CHR_BANK_BITS(CHR_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .address_i    (address_i),
    .data_i       (data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_kind_o (event_kind_o),
    .slot_o       (slot_o),
    .bank_value_o (bank_value_o),
    .irq_request_o(irq_request_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] reduce_bank(input logic [7:0] data);
    logic [8:0] rem;
    if (bank_count_m == 9'd0) begin
      return data;
    end
    rem = {1'b0, data} % bank_count_m;
    return rem[7:0];
  endfunction

  function automatic mapping_event_t predict_mapping(input logic kind_f,
                                                     input logic [15:0] addr,
                                                     input logic [7:0] data);
    mapping_event_t ev;
    ev = '0;
    if (kind_f == FUNC_TICK) begin
      // An armed counter fires one tick after it reaches zero, then disarms.
      if (line_armed) begin
        if (line_count == 8'd0) begin
          ev.irq = 1'b1;
          line_armed = 1'b0;
        end else begin
          line_count = line_count - 8'd1;
        end
      end
      return ev;
    end
    case (addr & ADDR_MASK)
      ADDR_PRG0: begin ev.kind = EV_PRG; ev.slot = 3'd0; ev.bank = reduce_bank(data); end
      ADDR_PRG1: begin ev.kind = EV_PRG; ev.slot = 3'd1; ev.bank = reduce_bank(data); end
      ADDR_PRG2: begin ev.kind = EV_PRG; ev.slot = 3'd2; ev.bank = reduce_bank(data); end
      ADDR_CHR0: begin ev.kind = EV_CHR; ev.slot = 3'd0; ev.bank = data & CHR_MASK; end
      ADDR_CHR1: begin ev.kind = EV_CHR; ev.slot = 3'd1; ev.bank = data & CHR_MASK; end
      ADDR_CHR2: begin ev.kind = EV_CHR; ev.slot = 3'd2; ev.bank = data & CHR_MASK; end
      ADDR_CHR3: begin ev.kind = EV_CHR; ev.slot = 3'd3; ev.bank = data & CHR_MASK; end
      ADDR_CHR4: begin ev.kind = EV_CHR; ev.slot = 3'd4; ev.bank = data & CHR_MASK; end
      ADDR_CHR5: begin ev.kind = EV_CHR; ev.slot = 3'd5; ev.bank = data & CHR_MASK; end
      ADDR_CHR6: begin ev.kind = EV_CHR; ev.slot = 3'd6; ev.bank = data & CHR_MASK; end
      ADDR_CHR7: begin ev.kind = EV_CHR; ev.slot = 3'd7; ev.bank = data & CHR_MASK; end
      ADDR_MIRROR: begin
        ev.kind = EV_MIRROR;
        ev.bank = data & MIRROR_MASK;
      end
      ADDR_IRQ_LTCH: line_reload = IRQ_FULL - data;
      ADDR_IRQ_CTRL: begin
        line_rearm = data[0];
        line_armed = data[1];
        line_count = line_reload;
      end
      ADDR_IRQ_ACK: begin
        line_armed = line_rearm;
        line_count = line_reload;
      end
      default: ;
    endcase
    return ev;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    mapping_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        report_mismatch("unexpected result", event_kind_o, 0);
      end else begin
        want = expected_events.pop_front();
        if (event_kind_o !== want.kind) report_mismatch("event_kind", event_kind_o, want.kind);
        if (slot_o !== want.slot) report_mismatch("slot", slot_o, want.slot);
        if (bank_value_o !== want.bank) report_mismatch("bank_value", bank_value_o, want.bank);
        if (irq_request_o !== want.irq) report_mismatch("irq_request", irq_request_o, want.irq);
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles < STALL_LIMIT) begin
        idle_cycles <= idle_cycles + 1;
      end else begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Valid stays high from one item to the next unless a gap is drawn.
  task automatic send_item(input logic kind_f, input logic [15:0] addr,
                           input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= kind_f;
    address_i <= addr;
    data_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    expected_events.push_back(predict_mapping(kind_f, addr, data));
    items_sent++;
  endtask

  task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
    send_item(FUNC_WRITE, addr, data);
  endtask

  task automatic send_tick();
    send_item(FUNC_TICK, 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_bank_count(input logic [8:0] count);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bank_count_m = count;
  endtask

  function automatic logic [15:0] decode_base(input int unsigned idx);
    case (idx)
      0: return ADDR_PRG0;
      1: return ADDR_PRG1;
      2: return ADDR_PRG2;
      3: return ADDR_CHR0;
      4: return ADDR_CHR1;
      5: return ADDR_CHR2;
      6: return ADDR_CHR3;
      7: return ADDR_CHR4;
      8: return ADDR_CHR5;
      9: return ADDR_CHR6;
      10: return ADDR_CHR7;
      11: return ADDR_MIRROR;
      12: return ADDR_IRQ_LTCH;
      13: return ADDR_IRQ_CTRL;
      14: return ADDR_IRQ_ACK;
      15: return SND_ADDR_LO;
      default: return SND_ADDR_HI;
    endcase
  endfunction

  // Half of the decoded writes also carry address bits that the decode ignores.
  function automatic logic [15:0] addr_noise();
    return $urandom_range(1) ? (16'($urandom) & ADDR_FREE_BITS) : 16'h0000;
  endfunction

  function automatic logic [7:0] random_data();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [8:0] pick_bank_count();
    case ($urandom_range(9))
      0: return 9'd2;
      1: return 9'd510;
      2: return 9'd0;
      3: return 9'd1;
      4: return 9'd511;
      5: return 9'($urandom_range(255, 256));
      default: return 9'($urandom_range(2, 510));
    endcase
  endfunction

  task automatic test_write_decode();
    send_write(ADDR_PRG0, 8'hff);
    send_write(ADDR_PRG1, 8'h00);
    send_write(ADDR_PRG2 | ADDR_FREE_BITS, 8'h5a);
    send_write(ADDR_CHR0, 8'hff);
    send_write(ADDR_CHR1, 8'h00);
    send_write(ADDR_CHR2, 8'h3f);
    send_write(ADDR_CHR3, 8'h40);
    send_write(ADDR_CHR4, 8'hc1);
    send_write(ADDR_CHR5, 8'h80);
    send_write(ADDR_CHR6, 8'h7f);
    send_write(ADDR_CHR7 | ADDR_FREE_BITS, 8'haa);
    send_write(ADDR_MIRROR, 8'hff);
    // Sound register writes must leave character bank 0 alone.
    send_write(SND_ADDR_LO, 8'h12);
    send_write(SND_ADDR_HI, 8'hff);
    send_write(16'h0000, 8'hff);
    send_write(16'hffff, 8'hff);
  endtask

  task automatic test_line_counter();
    send_tick();
    send_write(ADDR_IRQ_LTCH, 8'hfe);
    send_write(ADDR_IRQ_CTRL, 8'h03);
    send_tick();
    send_tick();
    send_tick();
    send_write(ADDR_IRQ_ACK, 8'h00);
    send_tick();
    send_tick();
  endtask

  task automatic test_bank_count_extremes();
    logic [8:0] count;
    for (int i = 0; i < 7; i++) begin
      case (i)
        0: count = 9'd0;
        1: count = 9'd1;
        2: count = 9'd2;
        3: count = 9'd255;
        4: count = 9'd256;
        5: count = 9'd510;
        default: count = 9'd511;
      endcase
      set_bank_count(count);
      send_write(ADDR_PRG0, 8'hff);
      send_write(ADDR_PRG1, 8'h00);
      send_write(ADDR_PRG2, 8'($urandom));
    end
  endtask

  // A well-formed interrupt setup followed by a run of scanline ticks, at times with an acknowledge and more ticks.
  task automatic line_irq_sequence();
    logic [7:0] ctrl;
    if ($urandom_range(1)) begin
      send_write(ADDR_IRQ_LTCH | addr_noise(), 8'($urandom_range(8'hf0, 8'hff)));
    end else begin
      send_write(ADDR_IRQ_LTCH | addr_noise(), random_data());
    end
    ctrl = 8'($urandom);
    if ($urandom_range(3) != 0) ctrl[1] = 1'b1;
    send_write(ADDR_IRQ_CTRL | addr_noise(), ctrl);
    repeat ($urandom_range(20)) send_tick();
    if ($urandom_range(1)) begin
      send_write(ADDR_IRQ_ACK | addr_noise(), random_data());
      repeat ($urandom_range(20)) send_tick();
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned s_pct,
                                     input int unsigned r_pct);
    int unsigned stop_at;
    int unsigned next_cfg;
    int unsigned pick;
    send_idle_pct = s_pct;
    stall_pct = r_pct;
    stop_at = items_sent + n_items;
    next_cfg = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        set_bank_count(pick_bank_count());
        next_cfg = items_sent + n_items / 4;
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_tick();
      end else if (pick < 35) begin
        line_irq_sequence();
      end else if (pick < 45) begin
        send_write(16'($urandom), random_data());
      end else begin
        send_write(decode_base($urandom_range(16)) | addr_noise(), random_data());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 31;
    stall_pct = 55;
    test_write_decode();
    test_line_counter();
    test_bank_count_extremes();
    test_random_traffic(PHASE_ITEMS, 31, 55);
    test_random_traffic(PHASE_ITEMS, 55, 31);
    test_random_traffic(PHASE_ITEMS, 0, 0);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/cbm_pkg.sv
hw/rtl/cartridge_bank_mapper_with_line_irq.sv
verif/cartridge_bank_mapper_with_line_irq_tb.sv
